// ===== rtl/warped_scan_correlation_score_defines.svh =====
// Assertion macros for the warped scan correlation score block.
// Included by the top level; no dependencies.
`ifndef WARPED_SCAN_CORRELATION_SCORE_DEFINES_SVH
`define WARPED_SCAN_CORRELATION_SCORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define WSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wsc_pkg.sv =====
// Shared types and constants for the warped scan correlation score block.
// No dependencies.
package wsc_pkg;

  localparam int CFG_DW = 24;
  localparam int CFG_IW = 3;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel;
    logic       last;
  } wsc_in_t;

  typedef struct packed {
    logic [23:0] score;
    logic        no_reference;
  } wsc_out_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_ROT_COS   = 3'd0,
    REG_ROT_SIN   = 3'd1,
    REG_SHIFT_X   = 3'd2,
    REG_SHIFT_Y   = 3'd3,
    REG_CUR_RES   = 3'd4,
    REG_REF_PPM   = 3'd5,
    REG_GRID_ROWS = 3'd6,
    REG_GRID_COLS = 3'd7
  } wsc_reg_e;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_GEOM, S_ROT, S_SUM, S_SCALE, S_MAP, S_WGT,
    S_TAP0, S_TAP1, S_TAP2, S_TAP3, S_TAPE, S_PROD, S_DIVI, S_DIV, S_OUT
  } wsc_state_t;

  typedef struct packed {
    logic       accept;
    logic       geom;
    logic       rot;
    logic       sum;
    logic       scale;
    logic       map_en;
    logic       wgt;
    logic       rd_en;
    logic [1:0] tap;
    logic       acc_clr;
    logic       acc_en;
    logic       prod;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } wsc_cmd_t;

  typedef struct packed {
    logic pend_last;
    logic ref_ok;
    logic div_done;
    logic out_busy;
  } wsc_status_t;

endpackage

// ===== rtl/warped_scan_correlation_score.sv =====
// Warped scan correlation score, top level. Reference pixels never make it busy.
// A current pixel passes accept, six geometry stages, four image reads on the
// single read port, last tap and product; a last one with a reference adds
// divider setup, the bit-serial divider and the output load, which waits while
// the output is stalled; without a reference it goes straight to the output load.
// Synchronous reset restores the registers and clears energy, sums, counters;
// the image store is not cleared and must be loaded before it is sampled.
`include "warped_scan_correlation_score_defines.svh"

module warped_scan_correlation_score #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [wsc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wsc_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  wsc_pkg::wsc_in_t           in_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output wsc_pkg::wsc_out_t          out_req
);
  import wsc_pkg::*;

  wsc_cmd_t    cmd;
  wsc_status_t status;

  wsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_req.op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  wsc_dpath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cmd       (cmd),
    .status    (status)
  );

  // A current pixel keeps the block busy on the following cycle
  `WSC_ASSERT_NEXT(a_scan_busy, clk, rst, cmd.accept && in_req.op == OP_SCAN, in_stall, "scan pixel did not start work")
  // A new result never overwrites one still waiting
  `WSC_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.out_load, !(out_valid && out_stall), "pending result overwritten")
  // Tap accumulation and divider steps never overlap request acceptance
  `WSC_ASSERT_NOW(a_acc_busy, clk, rst, cmd.acc_en || cmd.div_step, in_stall, "request taken during sampling")
endmodule

// ===== rtl/wsc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module wsc_ram #(
  parameter int W = 8,
  parameter int D = 65536
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/wsc_ctrl.sv =====
// Sequencer for the warped scan correlation score block.
// Depends on wsc_pkg.
module wsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_stall,
  input  wsc_pkg::wsc_status_t status,
  output wsc_pkg::wsc_cmd_t    cmd
);
  import wsc_pkg::*;

  wsc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_op == OP_SCAN) state_next = S_GEOM;
      end
      S_GEOM:  state_next = S_ROT;
      S_ROT:   state_next = S_SUM;
      S_SUM:   state_next = S_SCALE;
      S_SCALE: state_next = S_MAP;
      S_MAP:   state_next = S_WGT;
      S_WGT:   state_next = S_TAP0;
      S_TAP0:  state_next = S_TAP1;
      S_TAP1:  state_next = S_TAP2;
      S_TAP2:  state_next = S_TAP3;
      S_TAP3:  state_next = S_TAPE;
      S_TAPE:  state_next = S_PROD;
      S_PROD: begin
        if (!status.pend_last) state_next = S_IDLE;
        else if (status.ref_ok) state_next = S_DIVI;
        else state_next = S_OUT;
      end
      S_DIVI:  state_next = S_DIV;
      S_DIV: begin
        if (status.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE:  cmd.accept = in_valid;
      S_GEOM:  cmd.geom = 1'b1;
      S_ROT:   cmd.rot = 1'b1;
      S_SUM:   cmd.sum = 1'b1;
      S_SCALE: cmd.scale = 1'b1;
      S_MAP:   cmd.map_en = 1'b1;
      S_WGT:   cmd.wgt = 1'b1;
      S_TAP0: begin
        cmd.rd_en   = 1'b1;
        cmd.tap     = 2'd0;
        cmd.acc_clr = 1'b1;
      end
      S_TAP1: begin
        cmd.rd_en  = 1'b1;
        cmd.tap    = 2'd1;
        cmd.acc_en = 1'b1;
      end
      S_TAP2: begin
        cmd.rd_en  = 1'b1;
        cmd.tap    = 2'd2;
        cmd.acc_en = 1'b1;
      end
      S_TAP3: begin
        cmd.rd_en  = 1'b1;
        cmd.tap    = 2'd3;
        cmd.acc_en = 1'b1;
      end
      S_TAPE:  cmd.acc_en = 1'b1;
      S_PROD:  cmd.prod = 1'b1;
      S_DIVI:  cmd.div_init = 1'b1;
      S_DIV:   cmd.div_step = !status.div_done;
      S_OUT:   cmd.out_load = !status.out_busy;
      default: cmd = '0;
    endcase
  end
endmodule

// ===== rtl/wsc_dpath.sv =====
// Datapath: config registers, counters, geometry, bilinear taps, divider.
// Depends on wsc_pkg and wsc_ram.
module wsc_dpath #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wsc_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [wsc_pkg::CFG_DW-1:0]    cfg_data,
  input  wsc_pkg::wsc_in_t              in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wsc_pkg::wsc_out_t             out_req,
  input  wsc_pkg::wsc_cmd_t             cmd,
  output wsc_pkg::wsc_status_t          status
);
  import wsc_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int EHW   = (RW + 1 > 9) ? RW + 1 : 9;
  localparam int EWW   = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int DW    = ((RW > CW) ? RW : CW) + 2;
  localparam int XW    = DW + 21;
  localparam int DXW   = ((XW > 29) ? XW : 29) + 1;
  localparam int PW    = DXW + 16;
  localparam int XRW   = PW - 14;
  localparam int SW    = XRW + 25;
  localparam int MW    = SW - 15;
  localparam int FW    = MW - 16;
  localparam int NW    = 56;
  localparam int NCW   = 6;

  // Configuration registers
  logic signed [15:0] rot_cos, rot_sin;
  logic signed [23:0] shift_x, shift_y;
  logic [19:0]        cur_res;
  logic [23:0]        ref_ppm;
  logic [8:0]         grid_rows, grid_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cos   <= 16'sd16384;
      rot_sin   <= '0;
      shift_x   <= '0;
      shift_y   <= '0;
      cur_res   <= 20'd65536;
      ref_ppm   <= 24'd65536;
      grid_rows <= 9'd256;
      grid_cols <= 9'd256;
    end else if (cfg_we) begin
      case (wsc_reg_e'(cfg_index))
        REG_ROT_COS:   rot_cos   <= cfg_data[15:0];
        REG_ROT_SIN:   rot_sin   <= cfg_data[15:0];
        REG_SHIFT_X:   shift_x   <= cfg_data;
        REG_SHIFT_Y:   shift_y   <= cfg_data;
        REG_CUR_RES:   cur_res   <= cfg_data[19:0];
        REG_REF_PPM:   ref_ppm   <= cfg_data;
        REG_GRID_ROWS: grid_rows <= cfg_data[8:0];
        REG_GRID_COLS: grid_cols <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Effective grid size minus one, clamped to [0, MAX-1]
  logic [RW-1:0] hm;
  logic [CW-1:0] wm;
  always_comb begin
    if (grid_rows == 9'd0) hm = '0;
    else if (EHW'(grid_rows) > EHW'(MAX_ROWS)) hm = RW'(MAX_ROWS - 1);
    else hm = RW'(EHW'(grid_rows) - EHW'(1));
    if (grid_cols == 9'd0) wm = '0;
    else if (EWW'(grid_cols) > EWW'(MAX_COLS)) wm = CW'(MAX_COLS - 1);
    else wm = CW'(EWW'(grid_cols) - EWW'(1));
  end

  // Raster counters and scan state
  logic [RW-1:0] row_count, cur_v;
  logic [CW-1:0] col_count, cur_u;
  logic [7:0]    cur_pix;
  logic          cur_last;
  logic [47:0]   ref_energy, product_sum;
  logic          ref_loaded;
  logic          start;
  logic [CW:0]   col_p1;
  logic [RW:0]   row_p1;

  assign start  = (row_count == '0) && (col_count == '0);
  assign col_p1 = {1'b0, col_count} + 1'b1;
  assign row_p1 = {1'b0, row_count} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      col_count  <= '0;
      ref_energy <= '0;
      ref_loaded <= 1'b0;
      cur_last   <= 1'b0;
    end else if (cmd.accept) begin
      cur_last <= in_req.last;
      if (in_req.op == OP_LOAD) begin
        ref_energy <= (start ? 48'd0 : ref_energy)
                      + ({40'd0, in_req.pixel} * {40'd0, in_req.pixel});
        ref_loaded <= in_req.last ? 1'b1 : (start ? 1'b0 : ref_loaded);
      end
      if (in_req.last) begin
        row_count <= '0;
        col_count <= '0;
      end else if (col_p1 >= ({1'b0, wm} + 1'b1)) begin
        col_count <= '0;
        row_count <= (row_p1 >= ({1'b0, hm} + 1'b1)) ? '0 : row_p1[RW-1:0];
      end else begin
        col_count <= col_p1[CW-1:0];
      end
    end
  end

  // Captured pixel of the current request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_v   <= row_count;
      cur_u   <= col_count;
      cur_pix <= in_req.pixel;
    end
  end

  // Reference image store
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rd_data;
  assign waddr = AW'(row_count) * AW'(MAX_COLS) + AW'(col_count);

  wsc_ram #(.W(8), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.accept && in_req.op == OP_LOAD),
    .waddr (waddr),
    .wdata (in_req.pixel),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Metric position minus shift
  logic [DW-1:0]          dv, du;
  logic signed [XW-1:0]   x_c, y_c;
  logic signed [DXW-1:0]  dx, dy;
  assign dv  = DW'(hm) - (DW'(cur_v) << 1);
  assign du  = (DW'(cur_u) << 1) - DW'(wm);
  assign x_c = $signed(dv) * $signed({1'b0, cur_res});
  assign y_c = $signed(du) * $signed({1'b0, cur_res});

  always_ff @(posedge clk) begin
    if (cmd.geom) begin
      dx <= DXW'(x_c) - (DXW'(shift_x) <<< 5);
      dy <= DXW'(y_c) - (DXW'(shift_y) <<< 5);
    end
  end

  // Rotation products
  logic signed [PW-1:0] c_dx, s_dy, c_dy, s_dx;
  always_ff @(posedge clk) begin
    if (cmd.rot) begin
      c_dx <= rot_cos * dx;
      s_dy <= rot_sin * dy;
      c_dy <= rot_cos * dy;
      s_dx <= rot_sin * dx;
    end
  end

  // Rotated position, floor to Q.16
  logic signed [PW:0]    sum_x, sum_y;
  logic signed [XRW-1:0] xr, yr;
  assign sum_x = (PW+1)'(c_dx) + (PW+1)'(s_dy);
  assign sum_y = (PW+1)'(c_dy) - (PW+1)'(s_dx);
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      xr <= sum_x[PW:15];
      yr <= sum_y[PW:15];
    end
  end

  // Scale to reference pixels
  logic signed [SW-1:0] xs, ys;
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      xs <= xr * $signed({1'b0, ref_ppm});
      ys <= yr * $signed({1'b0, ref_ppm});
    end
  end

  // Pixel coordinates in Q.16
  logic signed [MW-1:0] mx, my;
  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      mx <= MW'($signed(ys[SW-1:16])) + MW'($signed({1'b0, wm, 15'd0}));
      my <= MW'($signed({1'b0, hm, 15'd0})) - MW'($signed(xs[SW-1:16]));
    end
  end

  // Tap coordinates with border replicate, and bilinear weights
  logic signed [FW:0] x0, x1, y0, y1;
  logic [CW-1:0]      xa_c, xb_c, xa, xb;
  logic [RW-1:0]      ya_c, yb_c;
  logic [AW-1:0]      base_a, base_b;
  logic [16:0]        fx, fy, gx, gy;
  logic [32:0]        wt [4];

  assign x0 = (FW+1)'($signed(mx[MW-1:16]));
  assign y0 = (FW+1)'($signed(my[MW-1:16]));
  assign x1 = x0 + (FW+1)'(1);
  assign y1 = y0 + (FW+1)'(1);
  assign fx = {1'b0, mx[15:0]};
  assign fy = {1'b0, my[15:0]};
  assign gx = 17'h10000 - fx;
  assign gy = 17'h10000 - fy;

  always_comb begin
    xa_c = (x0 < 0) ? '0 : ((x0 > (FW+1)'({1'b0, wm})) ? wm : x0[CW-1:0]);
    xb_c = (x1 < 0) ? '0 : ((x1 > (FW+1)'({1'b0, wm})) ? wm : x1[CW-1:0]);
    ya_c = (y0 < 0) ? '0 : ((y0 > (FW+1)'({1'b0, hm})) ? hm : y0[RW-1:0]);
    yb_c = (y1 < 0) ? '0 : ((y1 > (FW+1)'({1'b0, hm})) ? hm : y1[RW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.wgt) begin
      xa     <= xa_c;
      xb     <= xb_c;
      base_a <= AW'(ya_c) * AW'(MAX_COLS);
      base_b <= AW'(yb_c) * AW'(MAX_COLS);
      wt[0]  <= 33'(gx * gy);
      wt[1]  <= 33'(fx * gy);
      wt[2]  <= 33'(gx * fy);
      wt[3]  <= 33'(fx * fy);
    end
  end

  // Tap address select
  always_comb begin
    case (cmd.tap)
      2'd0:    raddr = base_a + AW'(xa);
      2'd1:    raddr = base_a + AW'(xb);
      2'd2:    raddr = base_b + AW'(xa);
      2'd3:    raddr = base_b + AW'(xb);
      default: raddr = base_a;
    endcase
  end

  // Weighted tap accumulation, one tap per cycle behind the read
  logic [1:0]  tap_q;
  logic [41:0] acc, acc_rnd;
  always_ff @(posedge clk) begin
    if (cmd.rd_en) tap_q <= cmd.tap;
    if (cmd.acc_clr) acc <= '0;
    else if (cmd.acc_en) acc <= acc + 42'(rd_data) * 42'(wt[tap_q]);
  end

  // Round sample to Q.8 (up to 255.0) and accumulate the product
  logic [15:0] sample;
  assign acc_rnd = acc + 42'(24'h800000);
  assign sample  = acc_rnd[39:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      product_sum <= '0;
    end else if (cmd.accept && in_req.op == OP_SCAN && start) begin
      product_sum <= '0;
    end else if (cmd.prod) begin
      product_sum <= product_sum + 48'(sample) * 48'(cur_pix);
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [47:0]    rem;
  logic [NW-1:0]  quo;
  logic [NCW-1:0] div_cnt;
  logic [48:0]    rem_sh;
  logic           q_bit;
  assign rem_sh = {rem, quo[NW-1]};
  assign q_bit  = (rem_sh >= {1'b0, ref_energy});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= '0;
      quo     <= {product_sum, 8'd0};
      div_cnt <= NCW'(NW);
    end else if (cmd.div_step) begin
      rem     <= q_bit ? 48'(rem_sh - {1'b0, ref_energy}) : rem_sh[47:0];
      quo     <= {quo[NW-2:0], q_bit};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Result register
  wsc_out_t result;
  always_comb begin
    if (!status.ref_ok) begin
      result.score        = 24'd65536;
      result.no_reference = 1'b1;
    end else begin
      result.score        = (quo[NW-1:24] != '0) ? 24'hFFFFFF : quo[23:0];
      result.no_reference = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_req <= result;
  end

  assign status.pend_last = cur_last;
  assign status.ref_ok    = ref_loaded && (ref_energy != '0);
  assign status.div_done  = (div_cnt == '0);
  assign status.out_busy  = out_valid && out_stall;
endmodule

// ===== verif/tb_warped_scan_correlation_score.sv =====
// Self-checking testbench for the warped scan correlation score block.
// Depends on wsc_pkg and the warped_scan_correlation_score RTL; nothing else.
`timescale 1ns / 100ps

module tb_warped_scan_correlation_score;
  import wsc_pkg::*;

  localparam int GRID_MAX = 256;
  localparam int N_ITEMS = 550;
  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  wsc_in_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wsc_out_t out_req;

  warped_scan_correlation_score dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scoreboard and run bookkeeping
  wsc_out_t score_q[$];
  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 53;
  longint cycles = 0;
  bit big_grid_used = 1'b0;

  // Shadow of the block: configuration, image store, accumulators, counters
  longint rot_c, rot_s, sh_x, sh_y, res_cur, ppm_ref;
  int rows_raw, cols_raw;
  byte unsigned ref_img[GRID_MAX*GRID_MAX];
  longint unsigned energy, prod_sum;
  int row_n, col_n;
  bit have_ref;

  function automatic int grid_dim(int raw);
    return raw < 1 ? 1 : (raw > GRID_MAX ? GRID_MAX : raw);
  endfunction

  // Full scan on small grids, a short early-closed scan on the wide ones
  function automatic int scan_len();
    int n;
    n = grid_dim(rows_raw) * grid_dim(cols_raw);
    return n > 36 ? 16 : n;
  endfunction

  function automatic longint clamp_to(longint v, longint hi);
    return v < 0 ? 0 : (v > hi ? hi : v);
  endfunction

  // Bilinear sample (Q.8) of the warped reference at the current counters
  function automatic longint warped_sample(int h, int w);
    longint hm, wm, x, y, dx, dy, xr, yr, mx, my, x0, y0, fx, fy, gx, gy;
    longint xa, xb, ya, yb, acc;
    hm = h - 1;
    wm = w - 1;
    x = (hm - 2 * row_n) * res_cur;
    y = (2 * col_n - wm) * res_cur;
    dx = x - sh_x * 32;
    dy = y - sh_y * 32;
    xr = (rot_c * dx + rot_s * dy) >>> 15;
    yr = (rot_c * dy - rot_s * dx) >>> 15;
    mx = ((yr * ppm_ref) >>> 16) + wm * 32768;
    my = hm * 32768 - ((xr * ppm_ref) >>> 16);
    x0 = mx >>> 16;
    y0 = my >>> 16;
    fx = mx & 65535;
    fy = my & 65535;
    gx = 65536 - fx;
    gy = 65536 - fy;
    xa = clamp_to(x0, wm);
    xb = clamp_to(x0 + 1, wm);
    ya = clamp_to(y0, hm);
    yb = clamp_to(y0 + 1, hm);
    acc = ref_img[ya*GRID_MAX+xa] * gx * gy + ref_img[ya*GRID_MAX+xb] * fx * gy
        + ref_img[yb*GRID_MAX+xa] * gx * fy + ref_img[yb*GRID_MAX+xb] * fx * fy;
    return (acc + (64'd1 << 23)) >> 24;
  endfunction

  // Advance the shadow by one accepted request; returns 1 with a score
  function automatic bit predict_pixel(wsc_in_t r, output wsc_out_t res);
    int h, w;
    bit start;
    longint unsigned q;
    h = grid_dim(rows_raw);
    w = grid_dim(cols_raw);
    start = (row_n == 0 && col_n == 0);
    predict_pixel = 1'b0;
    res = '0;
    if (r.op == OP_LOAD) begin
      if (start) begin
        energy = 0;
        have_ref = 1'b0;
      end
      ref_img[row_n*GRID_MAX+col_n] = r.pixel;
      energy = (energy + r.pixel * r.pixel) & 48'hFFFF_FFFF_FFFF;
      if (r.last) have_ref = 1'b1;
    end else begin
      if (start) prod_sum = 0;
      prod_sum = (prod_sum + warped_sample(h, w) * r.pixel) & 48'hFFFF_FFFF_FFFF;
      if (r.last) begin
        res.score = 24'd65536;
        res.no_reference = 1'b1;
        if (have_ref && energy != 0) begin
          q = (prod_sum << 8) / energy;
          res.score = q > 64'hFF_FFFF ? 24'hFF_FFFF : q[23:0];
          res.no_reference = 1'b0;
        end
        predict_pixel = 1'b1;
      end
    end
    // shared raster counters
    if (r.last) begin
      row_n = 0;
      col_n = 0;
    end else if (col_n + 1 >= w) begin
      col_n = 0;
      row_n = (row_n + 1 >= h) ? 0 : row_n + 1;
    end else begin
      col_n++;
    end
  endfunction

  // Drive one request and wait until it is taken; typed rows override the prediction
  task automatic send_pixel(logic op, logic [7:0] pix, logic last,
                            bit typed = 0, logic [23:0] t_score = 0, logic t_flag = 0);
    wsc_in_t r;
    wsc_out_t res;
    r.op = op;
    r.pixel = pix;
    r.last = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_pixel(r, res)) begin
      if (typed) begin
        res.score = t_score;
        res.no_reference = t_flag;
      end
      score_q.push_back(res);
    end
    items_sent++;
    if (items_sent > N_ITEMS * 2 / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (items_sent > N_ITEMS / 3) begin
      send_idle_pct = 53;
      recv_idle_pct = 22;
    end
  endtask

  // Hold requests until all scores are back, then let the pipeline drain
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (score_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(wsc_reg_e idx, logic [CFG_DW-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_ROT_COS:   rot_c = longint'($signed(v[15:0]));
      REG_ROT_SIN:   rot_s = longint'($signed(v[15:0]));
      REG_SHIFT_X:   sh_x = longint'($signed(v[23:0]));
      REG_SHIFT_Y:   sh_y = longint'($signed(v[23:0]));
      REG_CUR_RES:   res_cur = v[19:0];
      REG_REF_PPM:   ppm_ref = v[23:0];
      REG_GRID_ROWS: rows_raw = v[8:0];
      REG_GRID_COLS: cols_raw = v[8:0];
      default: ;
    endcase
  endtask

  // Random, well-formed pose and grid with the extremes mixed in
  task automatic write_random_setup();
    logic [15:0] c16, s16;
    logic [23:0] x24, y24, ppm;
    logic [19:0] res;
    logic [8:0] nr, nc;
    int pick;
    c16 = $urandom_range(3) == 0 ? 16'(-16384) : 16'($urandom_range(32768) - 16384);
    s16 = $urandom_range(3) == 0 ? 16'd16384 : 16'($urandom_range(32768) - 16384);
    case ($urandom_range(3))
      0: begin x24 = 24'h7F_FFFF; y24 = 24'h80_0000; end
      1: begin x24 = 24'h80_0000; y24 = 24'h7F_FFFF; end
      default: begin x24 = 24'($urandom_range(16384) - 8192); y24 = 24'($urandom); end
    endcase
    case ($urandom_range(4))
      0: res = 20'd0;
      1: res = 20'hF_FFFF;
      default: res = 20'($urandom_range(131072));
    endcase
    case ($urandom_range(4))
      0: ppm = 24'd0;
      1: ppm = 24'hFF_FFFF;
      default: ppm = 24'($urandom_range(262144));
    endcase
    // one clamped wide grid per run at most
    pick = big_grid_used ? 2 : int'($urandom_range(11));
    case (pick)
      0: begin nr = 9'd511; nc = 9'd0; big_grid_used = 1'b1; end
      1: begin nr = 9'd0; nc = 9'd300; big_grid_used = 1'b1; end
      default: begin nr = 9'($urandom_range(1, 6)); nc = 9'($urandom_range(1, 6)); end
    endcase
    write_reg(REG_ROT_COS, 24'(c16));
    write_reg(REG_ROT_SIN, 24'(s16));
    write_reg(REG_SHIFT_X, x24);
    write_reg(REG_SHIFT_Y, y24);
    write_reg(REG_CUR_RES, 24'(res));
    write_reg(REG_REF_PPM, ppm);
    write_reg(REG_GRID_ROWS, 24'(nr));
    write_reg(REG_GRID_COLS, 24'(nc));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_pixel(int flavor);
    case (flavor)
      0: return ($urandom_range(7) == 0) ? 8'd1 : 8'd0;
      1: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Whole reference scan from a known raster origin, so the store covers the grid
  task automatic load_reference(int flavor);
    int n;
    n = grid_dim(rows_raw) * grid_dim(cols_raw);
    send_pixel(OP_LOAD, rand_pixel(2), 1'b1);
    for (int i = 0; i < n; i++) send_pixel(OP_LOAD, rand_pixel(flavor), i == n - 1);
  endtask

  task automatic scan_current(int len, int flavor);
    for (int i = 0; i < len; i++) send_pixel(OP_SCAN, rand_pixel(flavor), i == len - 1);
  endtask

  // Directed rows on a 1x2 grid at the reset pose
  typedef struct {
    logic op;
    logic [7:0] pix;
    logic last;
    bit typed;
    logic [23:0] score;
    logic flag;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // store written but scan never closed: no reference
    '{OP_LOAD, 8'h00, 1'b0, 0, 0, 0}, '{OP_LOAD, 8'h00, 1'b0, 0, 0, 0},
    '{OP_SCAN, 8'hFF, 1'b0, 0, 0, 0}, '{OP_SCAN, 8'hFF, 1'b1, 1, 24'd65536, 1'b1},
    // closed reference of zeros: zero energy
    '{OP_LOAD, 8'h00, 1'b0, 0, 0, 0}, '{OP_LOAD, 8'h00, 1'b1, 0, 0, 0},
    '{OP_SCAN, 8'h07, 1'b0, 0, 0, 0}, '{OP_SCAN, 8'h09, 1'b1, 1, 24'd65536, 1'b1},
    // flat full-scale reference: identical scan gives 1.0, black scan gives 0
    '{OP_LOAD, 8'hFF, 1'b0, 0, 0, 0}, '{OP_LOAD, 8'hFF, 1'b1, 0, 0, 0},
    '{OP_SCAN, 8'hFF, 1'b0, 0, 0, 0}, '{OP_SCAN, 8'hFF, 1'b1, 1, 24'd65536, 1'b0},
    '{OP_SCAN, 8'h00, 1'b0, 0, 0, 0}, '{OP_SCAN, 8'h00, 1'b1, 1, 24'd0, 1'b0},
    // tiny energy, early last, and a mixed op sequence
    '{OP_LOAD, 8'h01, 1'b0, 0, 0, 0}, '{OP_LOAD, 8'h00, 1'b1, 0, 0, 0},
    '{OP_SCAN, 8'hAA, 1'b1, 0, 0, 0},
    '{OP_SCAN, 8'h55, 1'b0, 0, 0, 0}, '{OP_LOAD, 8'h01, 1'b0, 0, 0, 0},
    '{OP_SCAN, 8'h80, 1'b0, 0, 0, 0}, '{OP_SCAN, 8'h7F, 1'b1, 0, 0, 0}
  };

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_idle_pct);
  end

  // Compare every accepted score with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (score_q.size() == 0) begin
        $error("unexpected score %0d no_reference %0d", out_req.score, out_req.no_reference);
        errors++;
      end else begin
        if (out_req.score !== score_q[0].score) begin
          $error("score: expected %0d, actual %0d", score_q[0].score, out_req.score);
          errors++;
        end
        if (out_req.no_reference !== score_q[0].no_reference) begin
          $error("no_reference: expected %0d, actual %0d",
                 score_q[0].no_reference, out_req.no_reference);
          errors++;
        end
        void'(score_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int flavor;
    rot_c = 16384; rot_s = 0; sh_x = 0; sh_y = 0;
    res_cur = 65536; ppm_ref = 65536; rows_raw = 256; cols_raw = 256;
    energy = 0; prod_sum = 0; row_n = 0; col_n = 0; have_ref = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_GRID_ROWS, 24'd1);
    write_reg(REG_GRID_COLS, 24'd2);
    cfg_we <= 1'b0;

    // directed part
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].last,
                 dir_rows[i].typed, dir_rows[i].score, dir_rows[i].flag);

    // random phases
    while (items_sent < N_ITEMS) begin
      drain_block();
      write_random_setup();
      flavor = $urandom_range(3);
      load_reference(flavor);
      repeat ($urandom_range(2, 5)) begin
        case ($urandom_range(9))
          6: load_reference($urandom_range(3));
          7: scan_current($urandom_range(1, scan_len()), $urandom_range(3));
          8: begin
            // stray loads or scans, none of them last, that also move the shared counters
            repeat ($urandom_range(1, 3))
              send_pixel(1'($urandom_range(1)), rand_pixel(2), 1'b0);
          end
          9: begin
            // hold off until every score has come back
            in_valid <= 1'b0;
            @(posedge clk);
            while (score_q.size() != 0) @(posedge clk);
            scan_current(scan_len(), $urandom_range(3));
          end
          default: scan_current(scan_len(), $urandom_range(3));
        endcase
      end
    end

    drain_block();
    if (score_q.size() != 0) begin
      $error("%0d scores never arrived", score_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
